// File: hw/rtl/fgn1d_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and small tables for the 1-D fractal gradient noise block.
// No dependencies; imported by fractal_gradient_noise_1d_top.

package fgn1d_pkg;

    // Fixed-point layout of the coordinate and of the fade value
    localparam int FRAC_BITS   = 16;
    localparam int COORD_W     = 24;
    localparam int TABLE_SIZE  = 256;
    localparam int TABLE_AW    = $clog2(TABLE_SIZE);
    localparam int MAX_OCTAVES = 8;
    localparam int OCT_W       = 4;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Accumulator and divider widths
    localparam int ACC_W   = 34;
    localparam int MAG_W   = 32;
    localparam int X_W     = 25;
    localparam int RECIP_SHIFT = 30;

    localparam logic [16:0] FADE_ONE = 17'(1 << FRAC_BITS);

    // Item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // Sequencer states
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_OCT   = 8'b0000_0010,
        ST_ABS   = 8'b0000_0100,
        ST_ROUND = 8'b0000_1000,
        ST_RECIP = 8'b0001_0000,
        ST_CHECK = 8'b0010_0000,
        ST_FIX   = 8'b0100_0000,
        ST_SAT   = 8'b1000_0000
    } state_t;

    // Amplitude sum 2^k - 1 for k octaves
    function automatic logic [7:0] amp_sum(input logic [OCT_W-1:0] k);
        logic [8:0] full;
        full = (9'd1 << k) - 9'd1;
        return full[7:0];
    endfunction

    // floor(2^30 / (2^k - 1)); one correction step follows the multiply
    function automatic logic [30:0] amp_recip(input logic [OCT_W-1:0] k);
        logic [30:0] r;
        case (k)
            4'd1:    r = 31'd1073741824;
            4'd2:    r = 31'd357913941;
            4'd3:    r = 31'd153391689;
            4'd4:    r = 31'd71582788;
            4'd5:    r = 31'd34636833;
            4'd6:    r = 31'd17043521;
            4'd7:    r = 31'd8454660;
            4'd8:    r = 31'd4210752;
            default: r = 31'd1073741824;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/fractal_gradient_noise_1d_top.sv
`timescale 1ns / 1ps
// Top level of the 1-D fractal gradient noise block: permutation table, octave
// sequencer, shared multiplier and reciprocal-based normalizer. Depends on fgn1d_pkg.
//
//  channel   direction  handshake         payload
//  ------    ---------  ----------------  ------------------------------------------
//  command   in         start / busy      op, table_index, table_value,
//                                         coordinate, octave_count
//  result    out        done (strobe)     noise_value
//
// A table write word is taken in the cycle start is seen with busy low; it never
// raises busy and causes no result.
// An evaluate word with k octaves (1..8 after clamping) holds busy through eight steps per
// octave on the one shared 26x32 multiplier, then six normalizer states.
// done pulses for one cycle as busy drops; a new word may be started in that cycle.
// The receiver cannot stall; rst_n clears the sequencer but not the table, whose
// entries read as garbage until written.

module fractal_gradient_noise_1d_top
    import fgn1d_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    op,
    input  logic [7:0]              table_index,
    input  logic [7:0]              table_value,
    input  logic [23:0]             coordinate,
    input  logic [3:0]              octave_count,
    output logic                    done,
    output logic signed [15:0]      noise_value
);

    // Octave sub-steps; each issues at most one multiply and one table read
    localparam logic [2:0] STEP_SQ    = 3'd0;  // t*t, read perm[cell]
    localparam logic [2:0] STEP_CUBE  = 3'd1;  // t2*t, read perm[ha], build q
    localparam logic [2:0] STEP_FADE  = 3'd2;  // t3*q, read perm[next], latch ga
    localparam logic [2:0] STEP_VA    = 3'd3;  // ga*t, read perm[hb], cap u
    localparam logic [2:0] STEP_VB    = 3'd4;  // gb*(t-1), latch va
    localparam logic [2:0] STEP_DIFF  = 3'd5;  // vb-va, acc = 2*acc + va
    localparam logic [2:0] STEP_BLEND = 3'd6;  // u*(vb-va)
    localparam logic [2:0] STEP_ACC   = 3'd7;  // acc += blend term, next octave

    // Permutation table
    logic [7:0]               perm_mem [TABLE_SIZE];
    logic [TABLE_AW-1:0]      rd_addr;
    logic [7:0]               rd_data_reg;

    // Sequencer
    state_t                   state_reg, state_next;
    logic [2:0]               step_reg;
    logic [OCT_W-1:0]         oct_left_reg;
    logic [OCT_W-1:0]         k_reg;
    logic [OCT_W-1:0]         k_clamped;
    logic                     accept;

    // Octave datapath
    logic [COORD_W-1:0]       pos_reg;
    logic [FRAC_BITS-1:0]     t;
    logic [TABLE_AW-1:0]      cell_idx;
    logic [19:0]              q_reg;
    logic [19:0]              q_calc;
    logic [16:0]              u_reg;
    logic [19:0]              u_full;
    logic signed [7:0]        ga_reg;
    logic signed [24:0]       va_reg;
    logic signed [25:0]       diff_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    // Normalizer
    logic                     neg_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic [X_W-1:0]           x_reg;
    logic [X_W-1:0]           q0_reg;
    logic [X_W-1:0]           quo_reg;
    logic [7:0]               dsum;
    logic [25:0]              rem;
    logic [32:0]              round_sum;
    logic signed [15:0]       sat_value;

    // Shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic signed [MUL_P_W-1:0] prod_reg;

    logic                     done_reg;
    logic signed [15:0]       noise_reg;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign noise_value = noise_reg;

    assign t        = pos_reg[FRAC_BITS-1:0];
    assign cell_idx = pos_reg[COORD_W-1:FRAC_BITS];
    assign dsum     = amp_sum(k_reg);

    // Treat zero octaves as one, clamp above the maximum
    always_comb
    begin
        if (octave_count == '0)
            k_clamped = OCT_W'(1);
        else if (octave_count > OCT_W'(MAX_OCTAVES))
            k_clamped = OCT_W'(MAX_OCTAVES);
        else
            k_clamped = octave_count;
    end

    // Fade helper q = 6*t2 + 10*ONE - 15*t, never negative
    always_comb
    begin
        logic [20:0] t2w;
        logic [20:0] tw;
        logic [20:0] sum;
        t2w = {5'b0, prod_reg[31:16]};
        tw  = {5'b0, t};
        sum = (t2w << 2) + (t2w << 1) + 21'(10 << FRAC_BITS) - ((tw << 4) - tw);
        q_calc = sum[19:0];
    end

    assign u_full = prod_reg[35:16];

    // Table read address for the octave steps
    always_comb
    begin
        case (step_reg)
            STEP_SQ:   rd_addr = cell_idx;
            STEP_CUBE: rd_addr = rd_data_reg;
            STEP_FADE: rd_addr = cell_idx + TABLE_AW'(1);
            STEP_VA:   rd_addr = rd_data_reg;
            default:   rd_addr = cell_idx;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept && op == OP_WRITE)
            perm_mem[table_index] <= table_value;
        rd_data_reg <= perm_mem[rd_addr];
    end

    // Operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_OCT:
            begin
                case (step_reg)
                    STEP_SQ:
                    begin
                        mul_a = $signed({10'b0, t});
                        mul_b = $signed({16'b0, t});
                    end
                    STEP_CUBE:
                    begin
                        mul_a = $signed({10'b0, prod_reg[31:16]});
                        mul_b = $signed({16'b0, t});
                    end
                    STEP_FADE:
                    begin
                        mul_a = $signed({10'b0, prod_reg[31:16]});
                        mul_b = $signed({12'b0, q_reg});
                    end
                    STEP_VA:
                    begin
                        mul_a = {{18{ga_reg[7]}}, ga_reg};
                        mul_b = $signed({16'b0, t});
                    end
                    STEP_VB:
                    begin
                        // gb = entry - 128 is the entry with its top bit flipped
                        mul_a = $signed({{19{~rd_data_reg[7]}}, rd_data_reg[6:0]});
                        mul_b = $signed({16'hFFFF, t});
                    end
                    STEP_BLEND:
                    begin
                        mul_a = diff_reg;
                        mul_b = $signed({15'b0, u_reg});
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            ST_RECIP:
            begin
                mul_a = $signed({1'b0, x_reg});
                mul_b = $signed({1'b0, amp_recip(k_reg)});
            end
            ST_CHECK:
            begin
                mul_a = $signed({1'b0, prod_reg[RECIP_SHIFT+X_W-1:RECIP_SHIFT]});
                mul_b = $signed({24'b0, dsum});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
    end

    // Normalizer helpers
    assign round_sum = {1'b0, mag_reg} + {18'b0, dsum, 7'b0};
    assign rem       = {1'b0, x_reg} - prod_reg[25:0];

    always_comb
    begin
        if (neg_reg)
        begin
            if (quo_reg > X_W'(32768))
                sat_value = 16'sh8000;
            else
                sat_value = -$signed(quo_reg[15:0]);
        end
        else
        begin
            if (quo_reg > X_W'(32767))
                sat_value = 16'sh7FFF;
            else
                sat_value = $signed(quo_reg[15:0]);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && op == OP_EVAL)
                    state_next = ST_OCT;
            end
            ST_OCT:
            begin
                if (step_reg == STEP_ACC && oct_left_reg == OCT_W'(1))
                    state_next = ST_ABS;
            end
            ST_ABS:   state_next = ST_ROUND;
            ST_ROUND: state_next = ST_RECIP;
            ST_RECIP: state_next = ST_CHECK;
            ST_CHECK: state_next = ST_FIX;
            ST_FIX:   state_next = ST_SAT;
            ST_SAT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= STEP_SQ;
            oct_left_reg <= '0;
            k_reg        <= OCT_W'(1);
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_SAT);
            if (state_reg == ST_IDLE && accept && op == OP_EVAL)
            begin
                step_reg     <= STEP_SQ;
                oct_left_reg <= k_clamped;
                k_reg        <= k_clamped;
            end
            else if (state_reg == ST_OCT)
            begin
                // Advance the step; wrap to a new octave after the accumulate
                step_reg <= step_reg + 3'd1;
                if (step_reg == STEP_ACC)
                    oct_left_reg <= oct_left_reg - OCT_W'(1);
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept && op == OP_EVAL)
        begin
            pos_reg <= coordinate;
            acc_reg <= '0;
        end
        else if (state_reg == ST_OCT)
        begin
            case (step_reg)
                STEP_CUBE:
                    q_reg <= q_calc;
                STEP_FADE:
                    ga_reg <= $signed({~rd_data_reg[7], rd_data_reg[6:0]});
                STEP_VA:
                    u_reg <= (u_full > 20'(FADE_ONE)) ? FADE_ONE : u_full[16:0];
                STEP_VB:
                    va_reg <= prod_reg[24:0];
                STEP_DIFF:
                begin
                    diff_reg <= $signed({prod_reg[24], prod_reg[24:0]})
                                - $signed({va_reg[24], va_reg});
                    acc_reg  <= (acc_reg <<< 1) + ACC_W'(va_reg);
                end
                STEP_ACC:
                begin
                    acc_reg <= acc_reg + ACC_W'($signed(prod_reg[41:16]));
                    pos_reg <= pos_reg << 1;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            case (state_reg)
                ST_ABS:
                begin
                    neg_reg <= acc_reg[ACC_W-1];
                    mag_reg <= acc_reg[ACC_W-1] ? MAG_W'(-acc_reg) : MAG_W'(acc_reg);
                end
                ST_ROUND:
                    x_reg <= round_sum[32:8];
                ST_CHECK:
                    q0_reg <= prod_reg[RECIP_SHIFT+X_W-1:RECIP_SHIFT];
                ST_FIX:
                    quo_reg <= (rem >= {18'b0, dsum}) ? q0_reg + X_W'(1) : q0_reg;
                ST_SAT:
                    noise_reg <= sat_value;
                default:
                begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_done_after_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_SAT))
        else $error("done without a finished evaluation");

    a_eval_starts_octave: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_EVAL) |=> (state_reg == ST_OCT && step_reg == STEP_SQ))
        else $error("evaluate word did not start the octave loop");

    a_octaves_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OCT) |-> (oct_left_reg != '0 && oct_left_reg <= k_reg))
        else $error("octave counter out of range");

    a_fade_capped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OCT && step_reg == STEP_VB) |-> (u_reg <= FADE_ONE))
        else $error("fade weight above one");

    a_recip_within_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIX) |->
            ({1'b0, x_reg} >= prod_reg[25:0] && rem < {17'b0, dsum, 1'b0}))
        else $error("reciprocal quotient off by more than one");
`endif

endmodule
